// ===== hdl/gifip_pkg.sv =====
// gifip_pkg: shared widths, register indexes and interlace pass tables for
// the GIF interlace pixel placer. No dependencies.

package gifip_pkg;

	localparam int CoordW  = 16;
	localparam int ColW    = 17;
	localparam int AddrW   = 33;
	localparam int PixW    = 8;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_IMAGE_LEFT   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_TOP    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ROW_PITCH    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INTERLACED   = 3'd5;

	localparam logic [1:0] LAST_PASS = 2'd3;

	typedef struct packed {
		logic [CoordW-1:0] row;
		logic [ColW-1:0]   col;
		logic [1:0]        pass;
		logic              done;
	} place_t;

	function automatic logic [3:0] pass_start(input logic [1:0] p);
		logic [3:0] r;
		unique case (p)
			2'd0: r = 4'd0;
			2'd1: r = 4'd4;
			2'd2: r = 4'd2;
			2'd3: r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] pass_step(input logic [1:0] p);
		logic [3:0] r;
		unique case (p)
			2'd0: r = 4'd8;
			2'd1: r = 4'd8;
			2'd2: r = 4'd4;
			2'd3: r = 4'd2;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/gif_interlace_pixel_placer.sv =====
// Path: an accepted pixel is held in stage 1, then in the result register.
// Throughput: one pixel per cycle while the output is not stalled; the row/column/pass counters update in the
// same cycle as the input transfer, the address multiply sits in the next stage.
// Reset: clears counters, pipeline valids and loads register defaults
// (left 0, top 0, width 1, height 1, pitch 1, progressive order).
// Depends on gifip_pkg.

module gif_interlace_pixel_placer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [gifip_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [gifip_pkg::CoordW-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [gifip_pkg::PixW-1:0]           pixel_value,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gifip_pkg::AddrW-1:0]          write_address,
	output logic [gifip_pkg::PixW-1:0]           pixel_out,
	output logic                                 image_complete
);

	logic [gifip_pkg::CoordW-1:0] left_q, top_q, width_q, height_q, pitch_q;
	logic                         interlaced_q;

	gifip_pkg::place_t state_q, cur, nxt;

	logic                         produce;
	logic [gifip_pkg::ColW-1:0]   col_inc, col_end;
	logic [gifip_pkg::ColW-1:0]   r;
	logic [1:0]                   p;
	logic                         fin;

	logic                         accept_in, out_en;

	logic                         valid_s1;
	logic [gifip_pkg::ColW-1:0]   rowsum_s1;
	logic [gifip_pkg::ColW-1:0]   col_s1;
	logic [gifip_pkg::PixW-1:0]   pix_s1;
	logic                         done_s1;

	logic [gifip_pkg::AddrW-1:0]  addr_calc;

	logic                         out_valid_q;
	logic [gifip_pkg::AddrW-1:0]  addr_q;
	logic [gifip_pkg::PixW-1:0]   pix_q;
	logic                         done_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			top_q        <= '0;
			width_q      <= 16'd1;
			height_q     <= 16'd1;
			pitch_q      <= 16'd1;
			interlaced_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gifip_pkg::REG_IMAGE_LEFT:   left_q       <= cfg_data;
				gifip_pkg::REG_IMAGE_TOP:    top_q        <= cfg_data;
				gifip_pkg::REG_IMAGE_WIDTH:  width_q      <= cfg_data;
				gifip_pkg::REG_IMAGE_HEIGHT: height_q     <= cfg_data;
				gifip_pkg::REG_ROW_PITCH:    pitch_q      <= cfg_data;
				gifip_pkg::REG_INTERLACED:   interlaced_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// placement counters
	always_comb begin
		if (restart) begin
			cur.row  = '0;
			cur.col  = {1'b0, left_q};
			cur.pass = '0;
			cur.done = 1'b0;
		end else begin
			cur = state_q;
		end

		produce = !cur.done && (cur.row < height_q);
		col_inc = cur.col + 17'd1;
		col_end = {1'b0, left_q} + {1'b0, width_q};
		r       = '0;
		p       = cur.pass;
		fin     = 1'b0;
		nxt     = cur;

		if (produce) begin
			nxt.col = col_inc;
			if (col_inc >= col_end) begin
				nxt.col = {1'b0, left_q};
				if (interlaced_q) begin
					r = {1'b0, cur.row} + {13'd0, gifip_pkg::pass_step(cur.pass)};
					// skip passes whose first row lies beyond the height
					for (int i = 0; i < 4; i++) begin
						if (!fin && (r >= {1'b0, height_q})) begin
							if (p == gifip_pkg::LAST_PASS) begin
								fin = 1'b1;
							end else begin
								p = p + 2'd1;
								r = {13'd0, gifip_pkg::pass_start(p)};
							end
						end
					end
					nxt.pass = p;
					if (fin)
						nxt.done = 1'b1;
					else
						nxt.row = r[gifip_pkg::CoordW-1:0];
				end else begin
					r = {1'b0, cur.row} + 17'd1;
					if (r >= {1'b0, height_q})
						nxt.done = 1'b1;
					else
						nxt.row = r[gifip_pkg::CoordW-1:0];
				end
			end
		end
	end

	assign out_en    = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !out_en;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept_in) begin
			state_q <= nxt;
		end
	end

	// stage 1: row offset, column, pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= produce;
		end else if (out_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			rowsum_s1 <= {1'b0, cur.row} + {1'b0, top_q};
			col_s1    <= cur.col;
			pix_s1    <= pixel_value;
			done_s1   <= nxt.done;
		end
	end

	assign addr_calc = gifip_pkg::AddrW'(rowsum_s1) * gifip_pkg::AddrW'(pitch_q)
		+ gifip_pkg::AddrW'(col_s1);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s1) begin
			addr_q <= addr_calc;
			pix_q  <= pix_s1;
			done_q <= done_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_address  = addr_q;
	assign pixel_out      = pix_q;
	assign image_complete = done_q;

endmodule

// ===== hdl/gifip_checker.sv =====
// gifip_checker: port-level checks for gif_interlace_pixel_placer, bound to it.
// Depends on gifip_pkg for widths.

module gifip_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [gifip_pkg::PixW-1:0]        pixel_value,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [gifip_pkg::AddrW-1:0]       write_address,
	input logic [gifip_pkg::PixW-1:0]        pixel_out,
	input logic                              image_complete
);

	// held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_address)
			&& $stable(pixel_out) && $stable(image_complete))
		else $error("stalled result changed");

	// input only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// a result appearing on an empty output came from an input transfer through stage 1
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without input transfer");

	a_rise_pix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> pixel_out == $past(pixel_value, 2))
		else $error("result pixel mismatch");

endmodule

bind gif_interlace_pixel_placer gifip_checker u_gifip_checker (.*);
